// File: sv/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants for the duration scheduler
// Event codes, controller states and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package scd_pkg;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_START   = 2'd0,
    EV_RESTART = 2'd1,
    EV_STOP    = 2'd2
  } ev_kind_t;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_CALC   = 5'b00100,
    S_LAUNCH = 5'b01000,
    S_EMIT   = 5'b10000
  } ctl_state_t;

  // Divider geometry: the widest dividend is 60 * sample_count (30 bits).
  localparam int DIV_STEPS = 30;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Saturation limits of the frame counter and the frame duration.
  localparam logic [22:0]        COUNT_MAX = 23'h7F_FFFF;
  localparam logic signed [32:0] DUR_MAX   = 33'sd8388607;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic div_step;
    logic calc;
    logic launch;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_start;
    logic in_ch_ok;
    logic div_done;
    logic pend_any;
  } ctl_sts_t;

endpackage

// File: sv/scd_if.sv
// ----------------------------------------------------------------------------
// scd_if: input and result channel interfaces
// Valid/ready channels carrying the start/tick items and the event results.
// ----------------------------------------------------------------------------
interface scd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        channel;
  logic [31:0] source_address;
  logic [23:0] sample_count;
  logic [15:0] sample_rate;
  logic        repeat_req;

  modport source (
    output valid, action, channel, source_address, sample_count, sample_rate,
           repeat_req,
    input  ready
  );
  modport sink (
    input  valid, action, channel, source_address, sample_count, sample_rate,
           repeat_req,
    output ready
  );
endinterface

interface scd_out_if;
  logic        valid;
  logic        ready;
  logic        out_channel;
  logic [1:0]  event_kind;
  logic [15:0] timer_reload;
  logic [31:0] dma_source;
  logic        channel_active;
  logic        last;

  modport source (
    output valid, out_channel, event_kind, timer_reload, dma_source,
           channel_active, last,
    input  ready
  );
  modport sink (
    input  valid, out_channel, event_kind, timer_reload, dma_source,
           channel_active, last,
    output ready
  );
endinterface

// File: sv/scd_ctrl.sv
// ----------------------------------------------------------------------------
// scd_ctrl: sequencing state machine
// Accepts one item at a time, runs the divider for a start, commits the
// channel update and drains pending events into the output register.
// ----------------------------------------------------------------------------
module scd_ctrl import scd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          if (!sts.in_start) begin
            state_nxt = S_EMIT;
          end else if (sts.in_ch_ok) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_LAUNCH;
      end
      S_LAUNCH: begin
        cmd.launch = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (!sts.pend_any) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/scd_datapath.sv
// ----------------------------------------------------------------------------
// scd_datapath: divider, channel state and output register
// Three restoring division lanes share one step counter; per-channel frame
// counters, limits and pending events; a registered result stage.
// ----------------------------------------------------------------------------
module scd_datapath import scd_pkg::*; #(
  parameter int NCH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  scd_in_if.sink   in_ch,
  scd_out_if.source out_ch,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts
);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [46:0] div_iter(logic [16:0] rem, logic [29:0] nq,
                                           logic [15:0] dv);
    logic [16:0] sh;
    logic        qb;
    sh = {rem[15:0], nq[29]};
    qb = (sh >= {1'b0, dv});
    if (qb) sh = sh - {1'b0, dv};
    return {sh, nq[28:0], qb};
  endfunction

  logic accept, tick_go, start_go, load_out, out_free;

  // Captured start fields.
  logic                 ch_r;
  logic [31:0]          addr_cap_r;
  logic                 rep_cap_r;

  // Divider lanes: 60*count/rate, count/rate and 2^24/rate.
  logic [29:0]          nq1_r, nq2_r, nq3_r, nq1_nxt, nq2_nxt, nq3_nxt;
  logic [16:0]          rm1_r, rm2_r, rm3_r, rm1_nxt, rm2_nxt, rm3_nxt;
  logic [15:0]          dv_r, dv_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  // Derived duration and reload.
  logic [30:0]          b3;
  logic signed [32:0]   dur_full;
  logic [29:0]          neg_q3;
  logic [23:0]          dur_r;
  logic [15:0]          rld_r;

  // Per-channel state.
  logic [22:0]          cnt_r    [NCH];
  logic [22:0]          cnt_nxt  [NCH];
  logic [23:0]          lim_r    [NCH];
  logic [23:0]          lim_nxt  [NCH];
  logic                 play_r   [NCH];
  logic                 play_nxt [NCH];
  logic                 rep_r    [NCH];
  logic                 rep_nxt  [NCH];
  logic [31:0]          addr_r   [NCH];
  logic [31:0]          addr_nxt [NCH];
  logic [15:0]          rel_r    [NCH];
  logic [15:0]          rel_nxt  [NCH];
  logic [NCH-1:0]       pend_r, pend_nxt;
  ev_kind_t             kind_r   [NCH];
  ev_kind_t             kind_nxt [NCH];

  // Emission selection.
  logic [NCH-1:0]       sel_oh;
  logic                 sel_found;

  // Output register.
  logic                 ov_r;
  logic                 och_r;
  ev_kind_t             okind_r;
  logic [15:0]          orld_r;
  logic [31:0]          oaddr_r;
  logic                 oact_r;
  logic                 olast_r;

  // Handshake and status.
  assign in_ch.ready = cmd.in_ready;
  assign accept      = cmd.in_ready & in_ch.valid;
  assign tick_go     = accept & ~in_ch.action;
  assign start_go    = accept & in_ch.action & sts.in_ch_ok;
  assign out_free    = ~ov_r | out_ch.ready;
  assign load_out    = cmd.emit & (|pend_r) & out_free;

  assign sts.in_valid = in_ch.valid;
  assign sts.in_start = in_ch.action;
  assign sts.in_ch_ok = (int'(in_ch.channel) < NCH);
  assign sts.div_done = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sts.pend_any = |pend_r;

  // Divider: load on a start transfer, then one bit per lane each cycle.
  always_comb begin
    nq1_nxt  = nq1_r;
    nq2_nxt  = nq2_r;
    nq3_nxt  = nq3_r;
    rm1_nxt  = rm1_r;
    rm2_nxt  = rm2_r;
    rm3_nxt  = rm3_r;
    dv_nxt   = dv_r;
    step_nxt = step_r;
    if (start_go) begin
      nq1_nxt  = {in_ch.sample_count, 6'b0} - {4'b0, in_ch.sample_count, 2'b0};
      nq2_nxt  = {6'b0, in_ch.sample_count};
      nq3_nxt  = 30'h0100_0000;
      rm1_nxt  = '0;
      rm2_nxt  = '0;
      rm3_nxt  = '0;
      dv_nxt   = (in_ch.sample_rate == 16'd0) ? 16'd1 : in_ch.sample_rate;
      step_nxt = '0;
    end else if (cmd.div_step) begin
      {rm1_nxt, nq1_nxt} = div_iter(rm1_r, nq1_r, dv_r);
      {rm2_nxt, nq2_nxt} = div_iter(rm2_r, nq2_r, dv_r);
      {rm3_nxt, nq3_nxt} = div_iter(rm3_r, nq3_r, dv_r);
      step_nxt = step_r + STEP_W'(1);
    end
  end

  // Duration = a - 3b - 1, saturated at the top; reload = -(2^24/rate).
  assign b3       = {1'b0, nq2_r} + {nq2_r, 1'b0};
  assign dur_full = $signed({3'b0, nq1_r}) - $signed({2'b0, b3}) - 33'sd1;
  assign neg_q3   = 30'd0 - nq3_r;

  always_ff @(posedge clk) begin
    if (start_go) begin
      ch_r       <= in_ch.channel;
      addr_cap_r <= in_ch.source_address;
      rep_cap_r  <= in_ch.repeat_req;
    end
    nq1_r <= nq1_nxt;
    nq2_r <= nq2_nxt;
    nq3_r <= nq3_nxt;
    rm1_r <= rm1_nxt;
    rm2_r <= rm2_nxt;
    rm3_r <= rm3_nxt;
    dv_r  <= dv_nxt;
    if (cmd.calc) begin
      dur_r <= (dur_full > DUR_MAX) ? DUR_MAX[23:0] : dur_full[23:0];
      rld_r <= neg_q3[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Lowest pending channel goes out first.
  always_comb begin
    sel_oh    = '0;
    sel_found = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      if (pend_r[c] && !sel_found) begin
        sel_oh[c] = 1'b1;
        sel_found = 1'b1;
      end
    end
  end

  // Channel state: tick advance and expiry, launch commit, pending clear.
  always_comb begin
    logic [22:0] inc;
    logic        expd;
    pend_nxt = pend_r;
    for (int c = 0; c < NCH; c++) begin
      cnt_nxt[c]  = cnt_r[c];
      lim_nxt[c]  = lim_r[c];
      play_nxt[c] = play_r[c];
      rep_nxt[c]  = rep_r[c];
      addr_nxt[c] = addr_r[c];
      rel_nxt[c]  = rel_r[c];
      kind_nxt[c] = kind_r[c];
      inc  = (cnt_r[c] == COUNT_MAX) ? cnt_r[c] : cnt_r[c] + 23'd1;
      expd = $signed({2'b0, inc}) > $signed({lim_r[c][23], lim_r[c]});
      if (tick_go) begin
        cnt_nxt[c] = inc;
        if (expd && rep_r[c]) begin
          cnt_nxt[c]  = '0;
          play_nxt[c] = 1'b1;
          pend_nxt[c] = 1'b1;
          kind_nxt[c] = EV_RESTART;
        end else if (expd && play_r[c]) begin
          play_nxt[c] = 1'b0;
          pend_nxt[c] = 1'b1;
          kind_nxt[c] = EV_STOP;
        end
      end
      if (cmd.launch && int'(ch_r) == c) begin
        cnt_nxt[c]  = '0;
        lim_nxt[c]  = dur_r;
        play_nxt[c] = 1'b1;
        rep_nxt[c]  = rep_cap_r;
        addr_nxt[c] = addr_cap_r;
        rel_nxt[c]  = rld_r;
        pend_nxt[c] = 1'b1;
        kind_nxt[c] = EV_START;
      end
      if (load_out && sel_oh[c]) begin
        pend_nxt[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      addr_r[c] <= addr_nxt[c];
      rel_r[c]  <= rel_nxt[c];
      kind_r[c] <= kind_nxt[c];
    end
    if (!rst_n) begin
      pend_r <= '0;
      for (int c = 0; c < NCH; c++) begin
        cnt_r[c]  <= '0;
        lim_r[c]  <= '0;
        play_r[c] <= 1'b0;
        rep_r[c]  <= 1'b0;
      end
    end else begin
      pend_r <= pend_nxt;
      for (int c = 0; c < NCH; c++) begin
        cnt_r[c]  <= cnt_nxt[c];
        lim_r[c]  <= lim_nxt[c];
        play_r[c] <= play_nxt[c];
        rep_r[c]  <= rep_nxt[c];
      end
    end
  end

  // Output register: loads the selected event when the slot is free.
  always_ff @(posedge clk) begin
    if (load_out) begin
      olast_r <= ((pend_r & ~sel_oh) == '0);
      for (int c = 0; c < NCH; c++) begin
        if (sel_oh[c]) begin
          och_r   <= 1'(c);
          okind_r <= kind_r[c];
          oact_r  <= (kind_r[c] != EV_STOP);
          orld_r  <= (kind_r[c] == EV_STOP) ? 16'd0 : rel_r[c];
          oaddr_r <= (kind_r[c] == EV_STOP) ? 32'd0 : addr_r[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.out_channel    = och_r;
  assign out_ch.event_kind     = okind_r;
  assign out_ch.timer_reload   = orld_r;
  assign out_ch.dma_source     = oaddr_r;
  assign out_ch.channel_active = oact_r;
  assign out_ch.last           = olast_r;

endmodule

// File: sv/sound_channel_duration_scheduler.sv
// ----------------------------------------------------------------------------
// sound_channel_duration_scheduler: two-channel sample-playback scheduler
// Starts, restarts and stops sample playback on frame ticks.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_ch (valid/ready). A start item loads a channel's source
// address, sample count, rate and repeat flag; a tick item advances the frame
// counters of all channels. Results leave on out_ch, one per transfer, with
// last marking the final result of an input item.
// A start's result is valid once the bit-serial divider (three lanes in
// parallel) has run, the duration is computed, the channel is committed and
// the output register is loaded. A tick goes straight to loading the events
// it raises, one at a time. The next item is taken once all results of
// the current one are in the output register, so a waiting result does
// not block the input. While the receiver stalls, the output register
// holds its result and at most two further events, one per channel, wait
// behind it before the input closes. Reset clears all counters, limits and
// flags and empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sound_channel_duration_scheduler import scd_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  scd_in_if.sink    in_ch,
  scd_out_if.source out_ch
);

  // Only channels addressable by the one-bit channel field exist.
  localparam int NCH = (CHANNELS < 2) ? CHANNELS : 2;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  scd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  scd_datapath #(
    .NCH (NCH)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // No new item is taken while events are still waiting to go out.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pend_any |-> !in_ch.ready)
    else $error("input ready while events are pending");

  // A start on a live channel closes the input for the divider run.
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action && sts.in_ch_ok) |=> !in_ch.ready)
    else $error("input reopened right after a start transfer");

  // When the divider finishes while being stepped, the duration step follows.
  a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_done) |=> cmd.calc)
    else $error("divider finished without duration step");

endmodule

// File: verif/scd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_tb_pkg: shared verification codes for the duration scheduler
// Item action codes that both the stimulus and the checker use.
// ----------------------------------------------------------------------------
package scd_tb_pkg;

  // What an input item asks the scheduler to do.
  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } item_action_t;

endpackage

// File: verif/scd_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_event_checker: playback event predictor and result checker
// Watches both channels of the scheduler. Every accepted start or tick item
// updates a private copy of the per-channel playback state and queues the
// events that it should raise; every result transfer is compared field by
// field with the oldest queued event.
// ----------------------------------------------------------------------------
module scd_event_checker import scd_pkg::*, scd_tb_pkg::*; #(
  parameter int CHANNELS = 2
) (
  input  logic clk,
  input  logic rst_n,
  scd_in_if    in_ch,
  scd_out_if   out_ch,
  output int   mismatch_count,
  output int   events_pending
);

  // The channel field is one bit wide, so at most two channels exist.
  localparam int LIVE = (CHANNELS < 2) ? CHANNELS : 2;

  typedef struct {
    logic        chan;
    ev_kind_t    kind;
    logic [15:0] reload;
    logic [31:0] source;
    logic        active;
    logic        last;
  } sched_event_t;

  sched_event_t event_q[$];
  int           fail_tally;

  // Per-channel playback state.
  logic [22:0] frames      [2];
  int          frame_limit [2];
  logic        playing     [2];
  logic        looping     [2];
  logic [31:0] saved_addr  [2];
  logic [23:0] saved_count [2];
  logic [15:0] saved_rate  [2];

  // Timer reload: negated sample interval, low 16 bits; a zero rate counts as one.
  function automatic logic [15:0] reload_for(logic [15:0] rate);
    int unsigned divisor;
    int unsigned interval;
    divisor  = (rate == 16'd0) ? 32'd1 : {16'd0, rate};
    interval = 32'd16777216 / divisor;
    return 16'(32'd0 - interval);
  endfunction

  // Frame duration of a sound, saturated at the top of the counter range.
  function automatic int duration_for(logic [23:0] count, logic [15:0] rate);
    longint divisor;
    longint whole;
    longint part;
    longint span;
    divisor = (rate == 16'd0) ? 64'sd1 : longint'({48'd0, rate});
    whole   = (60 * longint'({40'd0, count})) / divisor;
    part    = longint'({40'd0, count}) / divisor;
    span    = whole - 3 * part - 1;
    if (span > DUR_MAX)
      span = DUR_MAX;
    return int'(span);
  endfunction

  function automatic void arm_channel(int chan, logic [31:0] addr, logic [23:0] count,
                                      logic [15:0] rate, logic rep);
    frames[chan]      = '0;
    saved_addr[chan]  = addr;
    saved_count[chan] = count;
    saved_rate[chan]  = rate;
    playing[chan]     = 1'b1;
    looping[chan]     = rep;
    frame_limit[chan] = duration_for(count, rate);
  endfunction

  function automatic void expect_event(int chan, ev_kind_t kind, logic [15:0] reload,
                                       logic [31:0] source, logic active);
    sched_event_t ev;
    ev.chan   = 1'(chan);
    ev.kind   = kind;
    ev.reload = reload;
    ev.source = source;
    ev.active = active;
    ev.last   = 1'b0;
    event_q.push_back(ev);
  endfunction

  // A start on an existing channel always reports exactly one event.
  function automatic void predict_start(logic chan, logic [31:0] addr, logic [23:0] count,
                                        logic [15:0] rate, logic rep);
    if (int'(chan) >= LIVE)
      return;
    arm_channel(int'(chan), addr, count, rate, rep);
    expect_event(int'(chan), EV_START, reload_for(rate), addr, 1'b1);
    event_q[event_q.size() - 1].last = 1'b1;
  endfunction

  // A tick advances every counter; expired channels restart or stop once.
  function automatic void predict_tick();
    int first;
    first = event_q.size();
    for (int c = 0; c < LIVE; c++) begin
      if (frames[c] != COUNT_MAX)
        frames[c] = frames[c] + 23'd1;
      if (int'({9'd0, frames[c]}) > frame_limit[c]) begin
        if (looping[c]) begin
          arm_channel(c, saved_addr[c], saved_count[c], saved_rate[c], 1'b1);
          expect_event(c, EV_RESTART, reload_for(saved_rate[c]), saved_addr[c], 1'b1);
        end else if (playing[c]) begin
          playing[c] = 1'b0;
          expect_event(c, EV_STOP, 16'd0, 32'd0, 1'b0);
        end
      end
    end
    if (event_q.size() > first)
      event_q[event_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_tally++;
    end
  endfunction

  function automatic void check_result();
    sched_event_t want;
    if (event_q.size() == 0) begin
      $error("result with no expected event: channel %0d kind %0d",
             out_ch.out_channel, out_ch.event_kind);
      fail_tally++;
      return;
    end
    want = event_q.pop_front();
    compare_field("out_channel", {31'd0, want.chan}, {31'd0, out_ch.out_channel});
    compare_field("event_kind", {30'd0, want.kind}, {30'd0, out_ch.event_kind});
    compare_field("timer_reload", {16'd0, want.reload}, {16'd0, out_ch.timer_reload});
    compare_field("dma_source", want.source, out_ch.dma_source);
    compare_field("channel_active", {31'd0, want.active}, {31'd0, out_ch.channel_active});
    compare_field("last", {31'd0, want.last}, {31'd0, out_ch.last});
  endfunction

  // Predict on every input transfer, check on every result transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      event_q.delete();
      fail_tally = 0;
      for (int c = 0; c < 2; c++) begin
        frames[c]      = '0;
        frame_limit[c] = 0;
        playing[c]     = 1'b0;
        looping[c]     = 1'b0;
        saved_addr[c]  = '0;
        saved_count[c] = '0;
        saved_rate[c]  = '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_START)
          predict_start(in_ch.channel, in_ch.source_address, in_ch.sample_count,
                        in_ch.sample_rate, in_ch.repeat_req);
        else
          predict_tick();
      end
      if (out_ch.valid && out_ch.ready)
        check_result();
    end
    mismatch_count <= fail_tally;
    events_pending <= event_q.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the sound channel duration scheduler
// Drives a directed run through the corner cases of starts and ticks, then
// random well-formed playback traffic under three idling patterns, while the
// event checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module testbench import scd_tb_pkg::*;;

  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASE_ITEMS  = 530;
  localparam int DRAIN_PERIOD = 200;

  logic clk = 1'b0;
  logic rst_n;
  int   src_idle_pct  = 6;
  int   sink_idle_pct = 45;
  int   quiet_cycles  = 0;
  int   mismatches;
  int   pending;

  scd_in_if  in_ch ();
  scd_out_if out_ch ();

  sound_channel_duration_scheduler #(
    .CHANNELS (2)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scd_event_checker #(
    .CHANNELS (2)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatches),
    .events_pending (pending)
  );

  always #1 clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, after an optional random gap, and hold it until its transfer.
  task automatic send_item(input item_action_t act, input logic chan,
                           input logic [31:0] addr, input logic [23:0] count,
                           input logic [15:0] rate, input logic rep);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.channel        <= chan;
    in_ch.source_address <= addr;
    in_ch.sample_count   <= count;
    in_ch.sample_rate    <= rate;
    in_ch.repeat_req     <= rep;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Ticks carry random content in the fields they ignore.
  task automatic send_tick();
    send_item(ACT_TICK, 1'($urandom_range(1)), $urandom, 24'($urandom), 16'($urandom),
              1'($urandom_range(1)));
  endtask

  // Mostly short sounds that expire within a few dozen ticks; some long ones.
  task automatic random_start();
    int unsigned pick;
    int unsigned rate;
    int unsigned span;
    int unsigned count;
    pick = $urandom_range(99);
    rate = (pick < 5) ? $urandom_range(255) : $urandom_range(65535, 256);
    span = $urandom_range(24);
    if (pick < 85)
      count = span * rate / 57 + $urandom_range(rate / 57);
    else
      count = $urandom;
    send_item(ACT_START, 1'($urandom_range(1)), $urandom, 24'(count), 16'(rate),
              1'($urandom_range(1)));
  endtask

  // Hold the input off until every expected event has arrived.
  task automatic await_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_items(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % DRAIN_PERIOD == DRAIN_PERIOD - 1)
        await_results();
      if ($urandom_range(99) < 15)
        random_start();
      else
        send_tick();
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_TICK;
    in_ch.channel        <= 1'b0;
    in_ch.source_address <= '0;
    in_ch.sample_count   <= '0;
    in_ch.sample_rate    <= '0;
    in_ch.repeat_req     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Shortest sound stops on the first tick; the next tick is quiet.
    send_item(ACT_START, 1'b0, 32'h0000_0000, 24'd1, 16'hFFFF, 1'b0);
    send_tick();
    send_tick();
    // Zero rate with the largest count saturates the duration.
    send_item(ACT_START, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'd0, 1'b1);
    // Rate below 256 and a duration of minus one repeats on every tick.
    send_item(ACT_START, 1'b0, 32'hA5A5_5A5A, 24'd1, 16'd255, 1'b1);
    send_tick();
    // Both channels repeating: two events on one tick.
    send_item(ACT_START, 1'b1, 32'h5A5A_A5A5, 24'd2, 16'd256, 1'b1);
    send_tick();
    send_tick();
    // Zero sample count stops at once while the other channel restarts.
    send_item(ACT_START, 1'b0, 32'h0000_FFFF, 24'd0, 16'd1000, 1'b0);
    send_tick();
    // A sound lasting exactly two frames.
    send_item(ACT_START, 1'b1, 32'hFFFF_0000, 24'd3, 16'd57, 1'b0);
    send_tick();
    send_tick();
    send_tick();
    // Long sounds at the top of the count and rate ranges.
    send_item(ACT_START, 1'b0, 32'h1234_5678, 24'hFF_FFFF, 16'hFFFF, 1'b0);
    send_item(ACT_START, 1'b1, 32'h8000_0001, 24'h80_0000, 16'h8000, 1'b0);
    send_tick();
    await_results();

    // Sender mostly busy, receiver often stalled.
    random_items(PHASE_ITEMS);
    await_results();

    // Sender often idle, receiver mostly ready.
    src_idle_pct  = 45;
    sink_idle_pct = 6;
    random_items(PHASE_ITEMS);
    await_results();

    // Back to back on both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_items(PHASE_ITEMS);
    await_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sound_channel_duration_scheduler.f
sv/scd_pkg.sv
sv/scd_if.sv
sv/scd_ctrl.sv
sv/scd_datapath.sv
sv/sound_channel_duration_scheduler.sv
verif/scd_tb_pkg.sv
verif/scd_event_checker.sv
verif/testbench.sv
